[hw/rtl/tnrx_pkg.sv]
// types and byte codes shared by the telnet receive negotiator modules
// no dependencies
package tnrx_pkg;

  // telnet command and character codes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DEL  = 8'd127;
  localparam logic [7:0] B_BS   = 8'd8;
  localparam logic [7:0] B_SP   = 8'd32;
  localparam logic [7:0] B_CR   = 8'd13;
  localparam logic [7:0] B_LF   = 8'd10;
  localparam logic [7:0] TELOPT_ECHO = 8'd1;
  localparam logic [7:0] TELOPT_SGA  = 8'd3;

  localparam logic [7:0] CAPACITY_RESET = 8'd77;
  localparam int unsigned MAX_RESULTS = 3;

  // line edit operations
  typedef enum logic [1:0] {
    LOP_NONE     = 2'd0,
    LOP_APPEND   = 2'd1,
    LOP_REMOVE   = 2'd2,
    LOP_COMPLETE = 2'd3
  } line_op_t;

  // receive parse state
  typedef enum logic [2:0] {
    PS_NORMAL = 3'd0,
    PS_IAC    = 3'd1,
    PS_WILL   = 3'd2,
    PS_WONT   = 3'd3,
    PS_DO     = 3'd4,
    PS_DONT   = 3'd5,
    PS_CR     = 3'd7
  } parse_state_t;

  // one result item
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    line_op_t   line_op;
    logic [7:0] line_char;
  } tnrx_result_t;

  // all results caused by one received byte
  typedef struct packed {
    logic [1:0]                         count;
    tnrx_result_t [MAX_RESULTS-1:0]     res;
  } tnrx_batch_t;

endpackage

[hw/rtl/tnrx_decode.sv]
// parse state, option flags, line length and capacity register; turns one
// received byte into a batch of up to three results. depends on tnrx_pkg
module tnrx_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_capacity,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  output tnrx_pkg::tnrx_batch_t batch
);
  import tnrx_pkg::*;

  parse_state_t state_r, state_nxt;
  logic         echo_r, echo_nxt;
  logic         sga_r, sga_nxt;
  logic [7:0]   len_r, len_nxt;
  logic [7:0]   cap_r;
  logic [7:0]   len_inc;
  logic         force_done;

  function automatic tnrx_result_t mk_res(input logic v, input logic [7:0] b,
                                          input line_op_t op, input logic [7:0] ch);
    tnrx_result_t r;
    r.tx_valid  = v;
    r.tx_byte   = v ? b : 8'd0;
    r.line_op   = op;
    r.line_char = (op == LOP_APPEND) ? ch : 8'd0;
    return r;
  endfunction

  // saturating length after an append and the forced completion check
  assign len_inc    = (len_r == 8'hff) ? len_r : len_r + 8'd1;
  assign force_done = (len_inc >= cap_r);

  // next state and results
  always_comb begin
    state_nxt   = PS_NORMAL;
    echo_nxt    = echo_r;
    sga_nxt     = sga_r;
    len_nxt     = len_r;
    batch.count = 2'd0;
    batch.res[0] = mk_res(1'b0, 8'd0, LOP_NONE, 8'd0);
    batch.res[1] = mk_res(1'b0, 8'd0, LOP_NONE, 8'd0);
    batch.res[2] = mk_res(1'b0, 8'd0, LOP_NONE, 8'd0);
    unique case (state_r)
      PS_IAC: begin
        case (rx_byte)
          B_IAC: begin
            batch.res[0] = mk_res(echo_r, rx_byte, LOP_APPEND, rx_byte);
            if (force_done) begin
              batch.res[1] = mk_res(1'b1, B_CR, LOP_NONE, 8'd0);
              batch.res[2] = mk_res(1'b1, B_LF, LOP_COMPLETE, 8'd0);
              batch.count  = 2'd3;
              len_nxt      = 8'd0;
            end else begin
              batch.count = 2'd1;
              len_nxt     = len_inc;
            end
          end
          B_WILL:  state_nxt = PS_WILL;
          B_WONT:  state_nxt = PS_WONT;
          B_DO:    state_nxt = PS_DO;
          B_DONT:  state_nxt = PS_DONT;
          default: state_nxt = PS_NORMAL;
        endcase
      end
      PS_WILL, PS_WONT: begin
        batch.res[0] = mk_res(1'b1, B_IAC, LOP_NONE, 8'd0);
        batch.res[1] = mk_res(1'b1, B_DONT, LOP_NONE, 8'd0);
        batch.res[2] = mk_res(1'b1, rx_byte, LOP_NONE, 8'd0);
        batch.count  = 2'd3;
      end
      PS_DO: begin
        if (rx_byte == TELOPT_SGA) begin
          sga_nxt = 1'b1;
          if (!sga_r) begin
            batch.res[0] = mk_res(1'b1, B_IAC, LOP_NONE, 8'd0);
            batch.res[1] = mk_res(1'b1, B_WILL, LOP_NONE, 8'd0);
            batch.res[2] = mk_res(1'b1, rx_byte, LOP_NONE, 8'd0);
            batch.count  = 2'd3;
          end
        end else if (rx_byte == TELOPT_ECHO) begin
          echo_nxt = 1'b1;
        end else begin
          batch.res[0] = mk_res(1'b1, B_IAC, LOP_NONE, 8'd0);
          batch.res[1] = mk_res(1'b1, B_WONT, LOP_NONE, 8'd0);
          batch.res[2] = mk_res(1'b1, rx_byte, LOP_NONE, 8'd0);
          batch.count  = 2'd3;
        end
      end
      PS_DONT: begin
        batch.res[0] = mk_res(1'b1, B_IAC, LOP_NONE, 8'd0);
        batch.res[1] = mk_res(1'b1, B_WONT, LOP_NONE, 8'd0);
        batch.res[2] = mk_res(1'b1, rx_byte, LOP_NONE, 8'd0);
        batch.count  = 2'd3;
      end
      PS_CR: begin
        // byte after cr is swallowed and ends the line
        batch.res[0] = mk_res(1'b1, B_CR, LOP_NONE, 8'd0);
        batch.res[1] = mk_res(1'b1, B_LF, LOP_COMPLETE, 8'd0);
        batch.count  = 2'd2;
        len_nxt      = 8'd0;
      end
      default: begin
        if (rx_byte == B_IAC) begin
          state_nxt = PS_IAC;
        end else if (rx_byte == B_CR) begin
          state_nxt = PS_CR;
        end else if (rx_byte == B_LF) begin
          batch.res[0] = mk_res(1'b1, B_CR, LOP_NONE, 8'd0);
          batch.res[1] = mk_res(1'b1, B_LF, LOP_COMPLETE, 8'd0);
          batch.count  = 2'd2;
          len_nxt      = 8'd0;
        end else if (rx_byte == B_DEL) begin
          if (len_r != 8'd0) begin
            batch.res[0] = mk_res(1'b1, B_BS, LOP_REMOVE, 8'd0);
            batch.res[1] = mk_res(1'b1, B_SP, LOP_NONE, 8'd0);
            batch.res[2] = mk_res(1'b1, B_BS, LOP_NONE, 8'd0);
            batch.count  = 2'd3;
            len_nxt      = len_r - 8'd1;
          end
        end else begin
          batch.res[0] = mk_res(echo_r, rx_byte, LOP_APPEND, rx_byte);
          if (force_done) begin
            batch.res[1] = mk_res(1'b1, B_CR, LOP_NONE, 8'd0);
            batch.res[2] = mk_res(1'b1, B_LF, LOP_COMPLETE, 8'd0);
            batch.count  = 2'd3;
            len_nxt      = 8'd0;
          end else begin
            batch.count = 2'd1;
            len_nxt     = len_inc;
          end
        end
      end
    endcase
  end

  // state registers, updated on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_NORMAL;
      echo_r  <= 1'b0;
      sga_r   <= 1'b0;
      len_r   <= 8'd0;
    end else if (accept) begin
      state_r <= state_nxt;
      echo_r  <= echo_nxt;
      sga_r   <= sga_nxt;
      len_r   <= len_nxt;
    end
  end

  // line capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_capacity;
    end
  end

endmodule

[hw/rtl/tnrx_serializer.sv]
// result register holding one batch of up to three results and sending them
// one per cycle while out_tready is high on the output stream. depends on tnrx_pkg
module tnrx_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_req,
  input  tnrx_pkg::tnrx_batch_t batch,
  output logic                  free,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output tnrx_pkg::tnrx_result_t out_res,
  output logic                  out_tlast
);
  import tnrx_pkg::*;

  tnrx_result_t [MAX_RESULTS-1:0] res_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  logic       busy;
  logic       out_fire;

  assign busy       = (cnt_r != 2'd0);
  assign out_tvalid = busy;
  assign out_res    = res_r[idx_r];
  assign out_tlast  = (idx_r == cnt_r - 2'd1);
  assign out_fire   = busy && out_tready;
  assign free       = !busy || (out_tready && out_tlast);

  // batch register and send pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      if (out_fire) begin
        if (out_tlast) begin
          cnt_r <= 2'd0;
          idx_r <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      if (load_req && free && batch.count != 2'd0) begin
        cnt_r <= batch.count;
        idx_r <= 2'd0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load_req && free) begin
      res_r <= batch.res;
    end
  end

  // send pointer stays inside the batch
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (idx_r < cnt_r))
    else $error("send pointer outside batch");

  // a result that is not the last one is followed by more
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_tlast) |=> (out_tvalid && idx_r == $past(idx_r) + 2'd1))
    else $error("batch ended early");

  // a stalled batch keeps its pointer
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(idx_r) && $stable(cnt_r)))
    else $error("pointer moved during stall");

endmodule

[hw/rtl/telnet_rx_option_negotiator_core.sv]
// top level of the telnet receive option negotiator and line editor
// depends on tnrx_pkg, tnrx_decode and tnrx_serializer
//
// usage:
//   in_*  : one received telnet byte per item in in_tdata[7:0]
//   out_* : results; each carries a byte to send back to the peer and/or a
//           line edit event, out_tlast marks the final result of one byte
//   cfg_* : writes the line capacity (chars before a line is forced done)
// latency: the first result of a byte appears on the cycle after it is accepted.
// throughput: a byte with no result does not occupy the output batch register. the
//   output batch register sends one result a cycle while out_tready is high and frees
//   up as its last result is taken, so a new byte is accepted in that same cycle.
// reset: parse state normal, echo and go-ahead suppression off, line empty,
//   capacity 77. cfg_ready is always high.
// stall: while out_tready is low the pending result holds and in_tready
//   stays low until the last result of the batch can go.
module telnet_rx_option_negotiator_core (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [0] tx_valid, [8:1] tx_byte, [10:9] line_op, [18:11] line_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  // cfg_data: [7:0] line_capacity
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tnrx_pkg::*;

  tnrx_batch_t  batch;
  tnrx_result_t out_res;
  logic         free;
  logic         in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = free;
  assign in_fire   = in_tvalid && free;

  // byte decode and negotiation state
  tnrx_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_capacity (cfg_data),
    .accept       (in_fire),
    .rx_byte      (in_tdata),
    .batch        (batch)
  );

  // result register and output sequencing
  tnrx_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_req   (in_fire),
    .batch      (batch),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res),
    .out_tlast  (out_tlast)
  );

  // pack result fields, lowest first
  assign out_tdata = {5'd0, out_res.line_char, out_res.line_op,
                      out_res.tx_byte, out_res.tx_valid};

endmodule

[test/telnet_rx_option_negotiator_core_test.sv]
// self-checking bench for telnet_rx_option_negotiator_core: drives received bytes and
// line capacity writes, predicts option replies and line edit items, checks every result
// depends on tnrx_pkg and the rtl of the negotiator core
`timescale 1ns / 1ps

module telnet_rx_option_negotiator_core_test;
  import tnrx_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;

  // one expected result item
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    line_op_t   line_op;
    logic [7:0] line_char;
    logic       last;
  } reply_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;

  // bytes waiting to go in, results waiting to come out
  logic [7:0]  rx_bytes_q[$];
  reply_word_t due_results[$];

  // negotiator state as the bench sees it
  parse_state_t rx_state  = PS_NORMAL;
  logic         echo_on   = 1'b0;
  logic         sga_on    = 1'b0;
  logic [7:0]   line_len  = 8'd0;
  logic [7:0]   line_cap  = CAPACITY_RESET;

  reply_word_t step_buf[MAX_RESULTS];
  int          step_n;

  int errors = 0;
  int idle_pct = 29;
  int holds_requested = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycles = 0;

  telnet_rx_option_negotiator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  task automatic note_result(input logic v, input logic [7:0] b, input line_op_t op,
                             input logic [7:0] ch);
    step_buf[step_n].tx_valid  = v;
    step_buf[step_n].tx_byte   = v ? b : 8'd0;
    step_buf[step_n].line_op   = op;
    step_buf[step_n].line_char = (op == LOP_APPEND) ? ch : 8'd0;
    step_buf[step_n].last      = 1'b0;
    step_n++;
  endtask

  task automatic close_line();
    note_result(1'b1, B_CR, LOP_NONE, 8'd0);
    note_result(1'b1, B_LF, LOP_COMPLETE, 8'd0);
    line_len = 8'd0;
    rx_state = PS_NORMAL;
  endtask

  // append, echoed only once the peer asked for echo; a full line is closed
  task automatic store_char(input logic [7:0] c);
    note_result(echo_on, c, LOP_APPEND, c);
    if (line_len < 8'd255) line_len++;
    if (line_len >= line_cap) close_line();
  endtask

  task automatic answer_option(input logic [7:0] cmd, input logic [7:0] opt);
    note_result(1'b1, B_IAC, LOP_NONE, 8'd0);
    note_result(1'b1, cmd, LOP_NONE, 8'd0);
    note_result(1'b1, opt, LOP_NONE, 8'd0);
  endtask

  // advance the parser by one received byte and queue what it should send
  task automatic negotiate_byte(input logic [7:0] c);
    step_n = 0;
    case (rx_state)
      PS_IAC: begin
        rx_state = PS_NORMAL;
        case (c)
          B_IAC:   store_char(c);
          B_WILL:  rx_state = PS_WILL;
          B_WONT:  rx_state = PS_WONT;
          B_DO:    rx_state = PS_DO;
          B_DONT:  rx_state = PS_DONT;
          default: ;
        endcase
      end
      PS_WILL, PS_WONT: begin
        rx_state = PS_NORMAL;
        answer_option(B_DONT, c);
      end
      PS_DO: begin
        rx_state = PS_NORMAL;
        if (c == TELOPT_SGA) begin
          if (!sga_on) answer_option(B_WILL, c);
          sga_on = 1'b1;
        end else if (c == TELOPT_ECHO) begin
          echo_on = 1'b1;
        end else begin
          answer_option(B_WONT, c);
        end
      end
      PS_DONT: begin
        rx_state = PS_NORMAL;
        answer_option(B_WONT, c);
      end
      PS_CR: close_line();
      default: begin
        rx_state = PS_NORMAL;
        if (c == B_IAC) begin
          rx_state = PS_IAC;
        end else if (c == B_CR) begin
          rx_state = PS_CR;
        end else if (c == B_LF) begin
          close_line();
        end else if (c == B_DEL) begin
          // erase echoes BS SP BS, nothing on an empty line
          if (line_len > 8'd0) begin
            note_result(1'b1, B_BS, LOP_REMOVE, 8'd0);
            note_result(1'b1, B_SP, LOP_NONE, 8'd0);
            note_result(1'b1, B_BS, LOP_NONE, 8'd0);
            line_len--;
          end
        end else begin
          store_char(c);
        end
      end
    endcase
    for (int k = 0; k < step_n; k++) begin
      step_buf[k].last = (k == step_n - 1);
      due_results.push_back(step_buf[k]);
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : byte_driver
    logic free;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
    end else begin
      if (in_tvalid && in_tready) negotiate_byte(in_tdata);
      free = !in_tvalid || in_tready;
      if (free) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= rx_bytes_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic check_result();
    reply_word_t want;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
               $time, out_tdata, out_tlast);
    end else begin
      want = due_results.pop_front();
      compare_field("tx_valid", want.tx_valid, out_tdata[0]);
      compare_field("tx_byte", want.tx_byte, out_tdata[8:1]);
      compare_field("line_op", int'(want.line_op), out_tdata[10:9]);
      compare_field("line_char", want.line_char, out_tdata[18:11]);
      compare_field("tdata padding", 0, out_tdata[23:19]);
      compare_field("tlast", want.last, out_tlast);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      // long back-pressure stretch on request
      if (holds_requested != holds_done) begin
        holds_done = holds_requested;
        hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send(input logic [7:0] b);
    rx_bytes_q.push_back(b);
  endtask

  // sender holds back until every queued byte went in and every result came out
  task automatic wait_idle();
    @(negedge clk);
    while (rx_bytes_q.size() != 0 || in_tvalid || due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    line_cap = v;
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed telnet traffic with random content, some noise
  task automatic random_traffic(input int n_items);
    int sent;
    int pick;
    logic [7:0] opt;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send(8'($urandom_range(126, 32)));
        sent += 1;
      end else if (pick < 58) begin
        send(B_DEL);
        sent += 1;
      end else if (pick < 64) begin
        send(B_CR);
        send(8'($urandom_range(255)));
        sent += 2;
      end else if (pick < 68) begin
        send(B_LF);
        sent += 1;
      end else if (pick < 84) begin
        case ($urandom_range(3))
          0: opt = TELOPT_SGA;
          1: opt = TELOPT_ECHO;
          default: opt = 8'($urandom_range(255));
        endcase
        send(B_IAC);
        send(B_WILL + 8'($urandom_range(3)));
        send(opt);
        sent += 3;
      end else if (pick < 88) begin
        send(B_IAC);
        send(B_IAC);
        sent += 2;
      end else if (pick < 90) begin
        // unknown command after IAC, dropped
        send(B_IAC);
        send(8'($urandom_range(250)));
        sent += 2;
      end else begin
        send(8'($urandom_range(255)));
        sent += 1;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // appends without echo, erase, erase on an empty line
    send(8'h41);
    send(8'h00);
    send(B_DEL);
    send(B_DEL);
    send(B_DEL);
    // do echo is silent, then appends echo
    send(B_IAC); send(B_DO); send(TELOPT_ECHO);
    send(8'h7e);
    // do sga answered once only
    send(B_IAC); send(B_DO); send(TELOPT_SGA);
    send(B_IAC); send(B_DO); send(TELOPT_SGA);
    // refusals and acknowledgement
    send(B_IAC); send(B_WILL); send(8'h18);
    send(B_IAC); send(B_WONT); send(8'hff);
    send(B_IAC); send(B_DONT); send(TELOPT_ECHO);
    send(B_IAC); send(B_DO); send(8'h00);
    // escaped iac appends 255, unknown command ignored
    send(B_IAC); send(B_IAC);
    send(B_IAC); send(8'h80);
    // byte after cr swallowed, even an iac
    send(B_CR); send(8'h41);
    send(B_CR); send(B_IAC);
    send(B_DONT);
    send(B_LF);
    wait_idle();

    // capacity lowered below the current line length
    set_capacity(8'd200);
    repeat (10) send(8'($urandom_range(126, 32)));
    wait_idle();
    set_capacity(8'd3);
    send(8'h7a);
    wait_idle();

    // zero capacity: every append closes the line
    set_capacity(8'd0);
    send(8'h71); send(8'h72); send(B_DEL);
    wait_idle();

    set_capacity(8'd1);
    random_traffic(30);
    wait_idle();

    // long line, run without any idling
    idle_pct = 0;
    set_capacity(8'd160);
    repeat (160) send(8'($urandom_range(126, 32)));
    random_traffic(20);
    wait_idle();
    idle_pct = 29;

    // receiver stalls a long time while bytes keep coming
    set_capacity(8'd8);
    holds_requested++;
    random_traffic(40);
    wait_idle();

    set_capacity(8'($urandom_range(255, 1)));
    random_traffic(30);
    wait_idle();

    set_capacity(8'd2);
    random_traffic(20);
    wait_idle();

    set_capacity(CAPACITY_RESET);
    random_traffic(20);
    wait_idle();

    if (errors == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/tnrx_pkg.sv
hw/rtl/tnrx_decode.sv
hw/rtl/tnrx_serializer.sv
hw/rtl/telnet_rx_option_negotiator_core.sv
test/telnet_rx_option_negotiator_core_test.sv
